### rtl/tdsd_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and the digit glyph table of the two-digit display driver
// no dependencies

package tdsd_pkg;

    localparam int PERIOD   = 20;
    localparam int PHASE_W  = 5;
    localparam int BRIGHT_W = 5;
    localparam int VALUE_W  = 12;
    localparam int SEG_W    = 8;
    localparam int DOT_IDX  = 7;

    // largest value in tenths that is still shown (99.0)
    localparam int MAX_TENTHS = 990;
    // first value in tenths shown as a whole number (10.0)
    localparam int INT_TENTHS = 100;

    typedef struct packed {
        logic [SEG_W-1:0] tens;
        logic [SEG_W-1:0] units;
    } seg_pair_t;

    // segments a-g in bits 0-6, active high
    function automatic logic [SEG_W-1:0] digit_glyph(input logic [3:0] digit);
        logic [SEG_W-1:0] glyph;
        unique case (digit)
            4'd0:    glyph = 8'h3F;
            4'd1:    glyph = 8'h06;
            4'd2:    glyph = 8'h5B;
            4'd3:    glyph = 8'h4F;
            4'd4:    glyph = 8'h66;
            4'd5:    glyph = 8'h6D;
            4'd6:    glyph = 8'h7D;
            4'd7:    glyph = 8'h07;
            4'd8:    glyph = 8'h7F;
            4'd9:    glyph = 8'h6F;
            default: glyph = '0;
        endcase
        return glyph;
    endfunction

endpackage

### rtl/tdsd_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for tick items and display results
// depends on tdsd_pkg

interface tdsd_tick_if;
    import tdsd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value_tenths;

    modport source (output valid, output value_tenths, input ready);
    modport sink   (input valid, input value_tenths, output ready);
endinterface

interface tdsd_disp_if;
    import tdsd_pkg::*;

    logic             valid;
    logic             ready;
    logic [SEG_W-1:0] tens_segments;
    logic [SEG_W-1:0] units_segments;

    modport source (output valid, output tens_segments, output units_segments, input ready);
    modport sink   (input valid, input tens_segments, input units_segments, output ready);
endinterface

### rtl/tdsd_decode.sv
`timescale 1ns / 1ps
// value in tenths to two seven-segment glyphs, blanked when dark or out of range
// depends on tdsd_pkg

module tdsd_decode (
    input  logic signed [tdsd_pkg::VALUE_W-1:0] value_tenths,
    input  logic                                lit,
    output tdsd_pkg::seg_pair_t                 segs
);
    import tdsd_pkg::*;

    logic        in_range;
    logic        int_mode;
    logic [9:0]  v;
    logic [10:0] x;
    logic [18:0] prod_q;
    logic [16:0] prod_h;
    logic [6:0]  q;
    logic [3:0]  hi;
    logic [3:0]  lo;
    logic [10:0] lo_full;

    always_comb
    begin
        in_range = !value_tenths[VALUE_W-1]
                   && (value_tenths[VALUE_W-2:0] <= 11'(MAX_TENTHS));
        v        = value_tenths[9:0];
        int_mode = value_tenths[VALUE_W-2:0] >= 11'(INT_TENTHS);

        // half-up rounding in whole-number mode
        x      = int_mode ? ({1'b0, v} + 11'd5) : {1'b0, v};
        // x / 10 by reciprocal, exact for x below 1029
        prod_q = 19'(x) * 19'd205;
        q      = prod_q[17:11];
        // x / 100 by reciprocal, exact for x below 1099
        prod_h = 17'(x) * 17'd41;

        if (int_mode)
        begin
            hi      = prod_h[15:12];
            lo_full = 11'(q) - 11'(hi) * 11'd10;
        end
        else
        begin
            hi      = q[3:0];
            lo_full = x - 11'(q) * 11'd10;
        end
        lo = lo_full[3:0];

        segs = '0;
        if (lit && in_range)
        begin
            segs.tens  = digit_glyph(hi);
            segs.units = digit_glyph(lo);
            if (!int_mode)
            begin
                segs.tens[DOT_IDX] = 1'b1;
            end
        end
    end

endmodule

### rtl/two_digit_seven_segment_driver_unit.sv
`timescale 1ns / 1ps
// each tick transfer passes the input stage and then the result register before its result is valid
// throughput: one tick per cycle while disp.ready holds, set by the combinational decode between the two registers
// reset: phase counter to 0, brightness to PERIOD (always lit), both stages empty
// brightness writes saturate to PERIOD and take effect on the next tick transfer
// depends on tdsd_pkg, tdsd_if and tdsd_decode

module two_digit_seven_segment_driver_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    tdsd_tick_if.sink                         tick,
    tdsd_disp_if.source                       disp,
    input  logic                              cfg_we,
    input  logic [tdsd_pkg::BRIGHT_W-1:0]     cfg_wdata
);
    import tdsd_pkg::*;

    // pwm state
    logic [PHASE_W-1:0]  phase_reg;
    logic [PHASE_W-1:0]  phase_next;
    logic [BRIGHT_W-1:0] bright_reg;

    // input stage: value and the lit decision taken at transfer time
    logic                      s1_valid_reg;
    logic signed [VALUE_W-1:0] s1_value_reg;
    logic                      s1_lit_reg;

    // result register
    logic      out_valid_reg;
    seg_pair_t out_seg_reg;
    seg_pair_t seg_next;

    logic tick_xfer;
    logic out_adv;
    logic s1_ready;

    // result register frees when empty or when its transfer completes
    assign out_adv   = !out_valid_reg || disp.ready;
    assign s1_ready  = !s1_valid_reg || out_adv;
    assign tick.ready = s1_ready;
    assign tick_xfer = tick.valid && s1_ready;

    // phase wraps at PERIOD-1 and steps on every tick, lit or dark
    assign phase_next = (phase_reg == PHASE_W'(PERIOD - 1)) ? '0 : phase_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            bright_reg    <= BRIGHT_W'(PERIOD);
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // saturating brightness write
            if (cfg_we)
            begin
                bright_reg <= (cfg_wdata > BRIGHT_W'(PERIOD)) ? BRIGHT_W'(PERIOD) : cfg_wdata;
            end
            if (tick_xfer)
            begin
                phase_reg    <= phase_next;
                s1_valid_reg <= 1'b1;
            end
            else if (out_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (tick_xfer)
        begin
            s1_value_reg <= tick.value_tenths;
            s1_lit_reg   <= phase_reg < bright_reg;
        end
        if (out_adv)
        begin
            out_seg_reg <= seg_next;
        end
    end

    // digit split, glyph lookup and blanking
    tdsd_decode u_decode (
        .value_tenths (s1_value_reg),
        .lit          (s1_lit_reg),
        .segs         (seg_next)
    );

    assign disp.valid          = out_valid_reg;
    assign disp.tens_segments  = out_seg_reg.tens;
    assign disp.units_segments = out_seg_reg.units;

`ifndef SYNTHESIS
    // phase never leaves its period
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg < PHASE_W'(PERIOD))
        else $error("phase counter out of range");

    // brightness stays saturated
    a_bright_sat: assert property (@(posedge clk) disable iff (!rst_n)
        bright_reg <= BRIGHT_W'(PERIOD))
        else $error("brightness above period");

    // a tick at the last phase wraps the counter
    a_phase_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_xfer && phase_reg == PHASE_W'(PERIOD - 1)) |=> phase_reg == '0)
        else $error("phase did not wrap");

    // zero brightness never marks a tick as lit
    a_dark_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_xfer && bright_reg == '0) |=> !s1_lit_reg)
        else $error("tick lit at zero brightness");

    // a held item in the input stage keeps its value while the output stalls
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_adv) |=> (s1_valid_reg && $stable(s1_value_reg)))
        else $error("input stage lost a stalled item");
`endif

endmodule
